[rtl/core/ray_sphere_intersect_assert.svh]
// assertion macros for the ray sphere block
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

// antecedent implies consequent on the same edge
`define RSI_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition never holds
`define RSI_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/core/rsi_pkg.sv]
`default_nettype none
package rsi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
	localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
	localparam longint COORD_MIN = -(64'sd1 <<< (CW - 1));

	localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
	localparam logic signed [31:0] Q30_NEG = 32'shC000_0000;
	localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

	// square root: 72 bit radicand, one root bit per stage
	localparam int SQ_RAD_W = 72;
	localparam int SQ_STEPS = 36;
	localparam int SQ_REM_W = 38;
	// divider: 63 bit numerator, 34 bit divisor, 31 quotient bits
	localparam int DIV_NUM_W = 63;
	localparam int DIV_DEN_W = 34;
	localparam int DIV_STEPS = 31;

	// valid shift line up to the result register
	localparam int PIPE_LAT = 5 + SQ_STEPS + 7 + SQ_STEPS + DIV_STEPS;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic        [30:0] hit_distance;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] toward_x;
		logic signed [31:0] toward_y;
		logic signed [31:0] toward_z;
	} result_t;

endpackage
`default_nettype wire

[rtl/core/rsi_sqrt.sv]
`default_nettype none
module rsi_sqrt import rsi_pkg::*; (
	input  wire logic                clk,
	input  wire logic [SQ_RAD_W-1:0] rad,
	output logic      [SQ_STEPS-1:0] root
);

	logic [SQ_REM_W-1:0] rem_s  [SQ_STEPS];
	logic [SQ_STEPS-1:0] root_s [SQ_STEPS];
	logic [SQ_RAD_W-1:0] rad_s  [SQ_STEPS];

	logic [SQ_REM_W-1:0] rem_nx  [SQ_STEPS];
	logic [SQ_STEPS-1:0] root_nx [SQ_STEPS];
	logic [SQ_RAD_W-1:0] rad_nx  [SQ_STEPS];

	// restoring square root, two radicand bits per stage
	always_comb begin
		logic [SQ_REM_W-1:0] pr_rem;
		logic [SQ_STEPS-1:0] pr_root;
		logic [SQ_RAD_W-1:0] pr_rad;
		logic [SQ_REM_W-1:0] rem_sh;
		logic [SQ_REM_W-1:0] trial;
		for (int k = 0; k < SQ_STEPS; k++) begin
			if (k == 0) begin
				pr_rem  = '0;
				pr_root = '0;
				pr_rad  = rad;
			end else begin
				pr_rem  = rem_s[k-1];
				pr_root = root_s[k-1];
				pr_rad  = rad_s[k-1];
			end
			rem_sh = {pr_rem[SQ_REM_W-3:0], pr_rad[SQ_RAD_W-1 -: 2]};
			trial  = {pr_root, 2'b01};
			if (rem_sh >= trial) begin
				rem_nx[k]  = rem_sh - trial;
				root_nx[k] = {pr_root[SQ_STEPS-2:0], 1'b1};
			end else begin
				rem_nx[k]  = rem_sh;
				root_nx[k] = {pr_root[SQ_STEPS-2:0], 1'b0};
			end
			rad_nx[k] = {pr_rad[SQ_RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			rem_s[k]  <= rem_nx[k];
			root_s[k] <= root_nx[k];
			rad_s[k]  <= rad_nx[k];
		end
	end

	assign root = root_s[SQ_STEPS-1];

endmodule
`default_nettype wire

[rtl/core/rsi_div.sv]
`default_nettype none
module rsi_div import rsi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	output logic      [DIV_STEPS-1:0] quo
);

	// quotient fits in DIV_STEPS bits, so the top numerator bits start below den
	logic [DIV_DEN_W:0]   rem_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] low_s [DIV_STEPS];
	logic [DIV_DEN_W-1:0] den_s [DIV_STEPS];

	logic [DIV_DEN_W:0]   rem_nx [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_nx [DIV_STEPS];
	logic [DIV_STEPS-1:0] low_nx [DIV_STEPS];
	logic [DIV_DEN_W-1:0] den_nx [DIV_STEPS];

	always_comb begin
		logic [DIV_DEN_W:0]   pr_rem;
		logic [DIV_STEPS-1:0] pr_quo;
		logic [DIV_STEPS-1:0] pr_low;
		logic [DIV_DEN_W-1:0] pr_den;
		logic [DIV_DEN_W:0]   rem_sh;
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (k == 0) begin
				pr_rem = (DIV_DEN_W + 1)'(num[DIV_NUM_W-1:DIV_STEPS]);
				pr_quo = '0;
				pr_low = num[DIV_STEPS-1:0];
				pr_den = den;
			end else begin
				pr_rem = rem_s[k-1];
				pr_quo = quo_s[k-1];
				pr_low = low_s[k-1];
				pr_den = den_s[k-1];
			end
			rem_sh = {pr_rem[DIV_DEN_W-1:0], pr_low[DIV_STEPS-1]};
			if (rem_sh >= {1'b0, pr_den}) begin
				rem_nx[k] = rem_sh - {1'b0, pr_den};
				quo_nx[k] = {pr_quo[DIV_STEPS-2:0], 1'b1};
			end else begin
				rem_nx[k] = rem_sh;
				quo_nx[k] = {pr_quo[DIV_STEPS-2:0], 1'b0};
			end
			low_nx[k] = {pr_low[DIV_STEPS-2:0], 1'b0};
			den_nx[k] = pr_den;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			rem_s[k] <= rem_nx[k];
			quo_s[k] <= quo_nx[k];
			low_s[k] <= low_nx[k];
			den_s[k] <= den_nx[k];
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule
`default_nettype wire

[rtl/core/ray_sphere_intersect.sv]
// ray sphere intersection, fully pipelined, one ray accepted every cycle
// throughput: one ray per cycle, busy stays low; the depth is set by the two
// bit-serial square root pipelines (36 stages each) and the normal dividers (31)
// reset: arst_n clears the valid line and the result strobe and loads the
// registers (center 0, radius 1.0); payload registers are not reset
`default_nettype none
`include "ray_sphere_intersect_assert.svh"
module ray_sphere_intersect import rsi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire ray_t        ray,
	output logic             done,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// carried ray data: origin and clamped direction
	typedef struct packed {
		logic [2:0][31:0] o;
		logic [2:0][31:0] d;
	} rc_t;

	// sideband alongside the first square root
	typedef struct packed {
		logic [36:0] b;
		rc_t         rc;
		logic        miss;
	} side1_t;

	// sideband alongside the second square root
	typedef struct packed {
		logic [30:0]      ts;
		logic [2:0][31:0] h;
		logic [2:0][32:0] nmag;
		logic [2:0]       nneg;
		logic [2:0][31:0] d;
		logic             miss;
	} side2_t;

	// sideband alongside the dividers
	typedef struct packed {
		logic [30:0]      ts;
		logic [2:0][31:0] h;
		logic [2:0]       nneg;
		logic [2:0][31:0] d;
		logic             miss;
		logic             len_zero;
	} side3_t;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [31:0] center_x_q, center_y_q, center_z_q;
	logic [30:0] radius_q;
	reg_idx_t    cfg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= 31'd65536;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CENTER_X: center_x_q <= pwdata;
				REG_CENTER_Y: center_y_q <= pwdata;
				REG_CENTER_Z: center_z_q <= pwdata;
				REG_RADIUS:   radius_q   <= pwdata[30:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CENTER_X: prdata = center_x_q;
			REG_CENTER_Y: prdata = center_y_q;
			REG_CENTER_Z: prdata = center_z_q;
			REG_RADIUS:   prdata = {1'b0, radius_q};
		endcase
	end

	// center, sign extended from the coordinate width
	logic signed [31:0] ctr [3];
	assign ctr[0] = 32'($signed(center_x_q[CW-1:0]));
	assign ctr[1] = 32'($signed(center_y_q[CW-1:0]));
	assign ctr[2] = 32'($signed(center_z_q[CW-1:0]));

	// ---------------------------------------------------------------
	// valid line: no stall anywhere, so it just shifts
	// ---------------------------------------------------------------
	logic                accept;
	logic [PIPE_LAT-1:0] vld_q;
	logic                done_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[PIPE_LAT-2:0], accept};
			done_q <= vld_q[PIPE_LAT-1];
		end
	end

	// ---------------------------------------------------------------
	// s1: sign extend origin, clamp direction, s = origin - center
	// ---------------------------------------------------------------
	logic signed [31:0] org_in [3];
	logic signed [31:0] dir_in [3];
	logic signed [31:0] dcl    [3];

	assign org_in[0] = 32'($signed(ray.origin_x[CW-1:0]));
	assign org_in[1] = 32'($signed(ray.origin_y[CW-1:0]));
	assign org_in[2] = 32'($signed(ray.origin_z[CW-1:0]));
	assign dir_in[0] = ray.dir_x;
	assign dir_in[1] = ray.dir_y;
	assign dir_in[2] = ray.dir_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dir_in[i] > Q30_ONE)
				dcl[i] = Q30_ONE;
			else if (dir_in[i] < Q30_NEG)
				dcl[i] = Q30_NEG;
			else
				dcl[i] = dir_in[i];
		end
	end

	logic signed [32:0] s_s1 [3];
	rc_t                rc_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s1[i]    <= 33'(org_in[i]) - 33'(ctr[i]);
			rc_s1.o[i] <= org_in[i];
			rc_s1.d[i] <= dcl[i];
		end
	end

	// ---------------------------------------------------------------
	// s2: d_i * s_i and s_i squared
	// ---------------------------------------------------------------
	logic signed [64:0] p_s2  [3];
	logic        [64:0] ss_s2 [3];
	logic signed [65:0] s_sq  [3];
	rc_t                rc_s2;

	always_comb begin
		for (int i = 0; i < 3; i++)
			s_sq[i] = 66'(s_s1[i]) * 66'(s_s1[i]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s2[i]  <= 65'($signed(rc_s1.d[i])) * 65'(s_s1[i]);
			ss_s2[i] <= s_sq[i][64:0];
		end
		rc_s2 <= rc_s1;
	end

	// ---------------------------------------------------------------
	// s3: b = sum of floored products, s.s summed
	// ---------------------------------------------------------------
	logic signed [36:0] b_s3;
	logic        [66:0] ssum_s3;
	rc_t                rc_s3;

	always_ff @(posedge clk) begin
		b_s3 <= 37'($signed(p_s2[0][64:30])) + 37'($signed(p_s2[1][64:30]))
			+ 37'($signed(p_s2[2][64:30]));
		ssum_s3 <= 67'(ss_s2[0]) + 67'(ss_s2[1]) + 67'(ss_s2[2]);
		rc_s3   <= rc_s2;
	end

	// ---------------------------------------------------------------
	// s4: b squared, radius squared
	// ---------------------------------------------------------------
	logic signed [36:0] b_neg;
	logic        [35:0] b_mag;
	logic        [71:0] bsq_s4;
	logic        [61:0] r2_s4;
	logic signed [36:0] b_s4;
	logic        [66:0] ssum_s4;
	rc_t                rc_s4;

	assign b_neg = -b_s3;
	assign b_mag = b_s3[36] ? b_neg[35:0] : b_s3[35:0];

	always_ff @(posedge clk) begin
		bsq_s4  <= 72'(b_mag) * 72'(b_mag);
		r2_s4   <= 62'(radius_q) * 62'(radius_q);
		b_s4    <= b_s3;
		ssum_s4 <= ssum_s3;
		rc_s4   <= rc_s3;
	end

	// ---------------------------------------------------------------
	// s5: discriminant, negative means miss
	// ---------------------------------------------------------------
	logic [72:0]         disc;
	logic [SQ_RAD_W-1:0] rad1_s5;
	side1_t              sd1_s5;

	assign disc = 73'(bsq_s4) + 73'(r2_s4) - 73'(ssum_s4);

	always_ff @(posedge clk) begin
		rad1_s5     <= disc[72] ? '0 : disc[71:0];
		sd1_s5.b    <= b_s4;
		sd1_s5.rc   <= rc_s4;
		sd1_s5.miss <= disc[72];
	end

	// first square root and its sideband delay
	logic [SQ_STEPS-1:0] root1;
	side1_t              sd1_dly [SQ_STEPS];

	rsi_sqrt u_sqrt_disc (
		.clk  (clk),
		.rad  (rad1_s5),
		.root (root1)
	);

	always_ff @(posedge clk) begin
		sd1_dly[0] <= sd1_s5;
		for (int k = 1; k < SQ_STEPS; k++)
			sd1_dly[k] <= sd1_dly[k-1];
	end

	side1_t sd1_o;
	assign sd1_o = sd1_dly[SQ_STEPS-1];

	// ---------------------------------------------------------------
	// s6: roots t1 = -b - sqrt(d), t2 = -b + sqrt(d)
	// ---------------------------------------------------------------
	logic signed [38:0] nb;
	logic signed [38:0] t1_s6, t2_s6;
	rc_t                rc_s6;
	logic               miss_s6;

	assign nb = -39'($signed(sd1_o.b));

	always_ff @(posedge clk) begin
		t1_s6   <= nb - 39'(root1);
		t2_s6   <= nb + 39'(root1);
		rc_s6   <= sd1_o.rc;
		miss_s6 <= sd1_o.miss;
	end

	// ---------------------------------------------------------------
	// s7: near root when positive, else far root; saturate
	// ---------------------------------------------------------------
	logic signed [38:0] t_sel;
	logic        [30:0] ts_s7;
	rc_t                rc_s7;
	logic               miss_s7;

	assign t_sel = (t1_s6 > 39'sd0) ? t1_s6 : t2_s6;

	always_ff @(posedge clk) begin
		ts_s7   <= (t_sel > 39'(DIST_MAX)) ? DIST_MAX : t_sel[30:0];
		miss_s7 <= miss_s6 || t2_s6[38];
		rc_s7   <= rc_s6;
	end

	// ---------------------------------------------------------------
	// s8: distance times direction
	// ---------------------------------------------------------------
	logic signed [63:0] m_s8 [3];
	logic        [30:0] ts_s8;
	rc_t                rc_s8;
	logic               miss_s8;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			m_s8[i] <= 64'($signed({1'b0, ts_s7})) * 64'($signed(rc_s7.d[i]));
		ts_s8   <= ts_s7;
		rc_s8   <= rc_s7;
		miss_s8 <= miss_s7;
	end

	// ---------------------------------------------------------------
	// s9: hit point, saturated to the coordinate range
	// ---------------------------------------------------------------
	logic signed [34:0] hsum [3];
	logic signed [31:0] h_s9 [3];
	logic        [30:0] ts_s9;
	rc_t                rc_s9;
	logic               miss_s9;

	always_comb begin
		for (int i = 0; i < 3; i++)
			hsum[i] = 35'($signed(rc_s8.o[i])) + 35'($signed(m_s8[i][63:30]));
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (hsum[i] > 35'(COORD_MAX))
				h_s9[i] <= 32'(COORD_MAX);
			else if (hsum[i] < 35'(COORD_MIN))
				h_s9[i] <= 32'(COORD_MIN);
			else
				h_s9[i] <= hsum[i][31:0];
		end
		ts_s9   <= ts_s8;
		rc_s9   <= rc_s8;
		miss_s9 <= miss_s8;
	end

	// ---------------------------------------------------------------
	// s10: n = hit point - center
	// ---------------------------------------------------------------
	logic signed [32:0] n_s10 [3];
	logic signed [31:0] h_s10 [3];
	logic        [30:0] ts_s10;
	rc_t                rc_s10;
	logic               miss_s10;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			n_s10[i] <= 33'(h_s9[i]) - 33'(ctr[i]);
			h_s10[i] <= h_s9[i];
		end
		ts_s10   <= ts_s9;
		rc_s10   <= rc_s9;
		miss_s10 <= miss_s9;
	end

	// ---------------------------------------------------------------
	// s11: n squared, magnitude and sign
	// ---------------------------------------------------------------
	logic signed [65:0] n_sq    [3];
	logic signed [33:0] n_neg   [3];
	logic        [64:0] nsq_s11 [3];
	logic        [32:0] nmag_s11 [3];
	logic        [2:0]  nneg_s11;
	logic signed [31:0] h_s11 [3];
	logic        [30:0] ts_s11;
	rc_t                rc_s11;
	logic               miss_s11;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_sq[i]  = 66'(n_s10[i]) * 66'(n_s10[i]);
			n_neg[i] = -34'(n_s10[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nsq_s11[i]  <= n_sq[i][64:0];
			nmag_s11[i] <= n_s10[i][32] ? n_neg[i][32:0] : n_s10[i][32:0];
			nneg_s11[i] <= n_s10[i][32];
			h_s11[i]    <= h_s10[i];
		end
		ts_s11   <= ts_s10;
		rc_s11   <= rc_s10;
		miss_s11 <= miss_s10;
	end

	// ---------------------------------------------------------------
	// s12: n.n for the normal length
	// ---------------------------------------------------------------
	logic [SQ_RAD_W-1:0] rad2_s12;
	side2_t              sd2_s12;

	always_ff @(posedge clk) begin
		rad2_s12 <= SQ_RAD_W'(67'(nsq_s11[0]) + 67'(nsq_s11[1]) + 67'(nsq_s11[2]));
		for (int i = 0; i < 3; i++) begin
			sd2_s12.h[i]    <= h_s11[i];
			sd2_s12.nmag[i] <= nmag_s11[i];
		end
		sd2_s12.nneg <= nneg_s11;
		sd2_s12.d    <= rc_s11.d;
		sd2_s12.ts   <= ts_s11;
		sd2_s12.miss <= miss_s11;
	end

	// second square root: normal length
	logic [SQ_STEPS-1:0] len;
	side2_t              sd2_dly [SQ_STEPS];

	rsi_sqrt u_sqrt_len (
		.clk  (clk),
		.rad  (rad2_s12),
		.root (len)
	);

	always_ff @(posedge clk) begin
		sd2_dly[0] <= sd2_s12;
		for (int k = 1; k < SQ_STEPS; k++)
			sd2_dly[k] <= sd2_dly[k-1];
	end

	side2_t sd2_o;
	side3_t sd3_in;
	assign sd2_o = sd2_dly[SQ_STEPS-1];

	always_comb begin
		sd3_in.ts       = sd2_o.ts;
		sd3_in.h        = sd2_o.h;
		sd3_in.nneg     = sd2_o.nneg;
		sd3_in.d        = sd2_o.d;
		sd3_in.miss     = sd2_o.miss;
		sd3_in.len_zero = (len == '0);
	end

	// ---------------------------------------------------------------
	// dividers: |n_i| * 2^30 / len, one per axis
	// ---------------------------------------------------------------
	logic [DIV_STEPS-1:0] quo [3];

	for (genvar g = 0; g < 3; g++) begin : g_div
		rsi_div u_div (
			.clk (clk),
			.num ({sd2_o.nmag[g], 30'b0}),
			.den (len[DIV_DEN_W-1:0]),
			.quo (quo[g])
		);
	end

	side3_t sd3_dly [DIV_STEPS];

	always_ff @(posedge clk) begin
		sd3_dly[0] <= sd3_in;
		for (int k = 1; k < DIV_STEPS; k++)
			sd3_dly[k] <= sd3_dly[k-1];
	end

	side3_t sd3_o;
	assign sd3_o = sd3_dly[DIV_STEPS-1];

	// ---------------------------------------------------------------
	// result register: signs, degenerate normal, miss clears everything
	// ---------------------------------------------------------------
	logic signed [31:0] nrm [3];
	logic signed [31:0] twd [3];
	result_t            res_nx;
	result_t            result_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sd3_o.len_zero)
				nrm[i] = '0;
			else if (sd3_o.nneg[i])
				nrm[i] = -32'(quo[i]);
			else
				nrm[i] = 32'(quo[i]);
			twd[i] = -$signed(sd3_o.d[i]);
		end
		res_nx.hit          = 1'b1;
		res_nx.hit_distance = sd3_o.ts;
		res_nx.hit_x        = sd3_o.h[0];
		res_nx.hit_y        = sd3_o.h[1];
		res_nx.hit_z        = sd3_o.h[2];
		res_nx.normal_x     = nrm[0];
		res_nx.normal_y     = nrm[1];
		res_nx.normal_z     = nrm[2];
		res_nx.toward_x     = twd[0];
		res_nx.toward_y     = twd[1];
		res_nx.toward_z     = twd[2];
		if (sd3_o.miss)
			res_nx = '0;
	end

	always_ff @(posedge clk) begin
		result_q <= res_nx;
	end

	assign done   = done_q;
	assign result = result_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`RSI_ASSERT_IMPL(a_miss_cleared, done && !result.hit, result.hit_distance == '0 && result.normal_x == '0 && result.toward_x == '0, "miss result carries data")
	`RSI_ASSERT_NEVER(a_toward_range, done && result.hit && (result.toward_x > Q30_ONE || result.toward_x < Q30_NEG), "toward out of range")

endmodule
`default_nettype wire

[bench/ray_sphere_intersect_test.sv]
`timescale 1ns / 1ps
module ray_sphere_intersect_test;
	import rsi_pkg::*;

	localparam int PIPE_CYCLES = 116;
	localparam logic signed [31:0] Q16_ONE = 32'sd65536;

	// directed row: a ray plus an optional hand-typed result
	typedef struct {
		ray_t    ray;
		bit      pinned;
		result_t result;
	} probe_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	ray_t    ray;
	logic    done;
	result_t result;
	logic    psel;
	logic    penable;
	logic    pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// sphere setting as the block should hold it
	logic signed [31:0] sphere_center [3];
	logic        [30:0] sphere_rad;

	result_t pending_hits [$];
	int      error_count;
	int      ray_count;

	// tag that travels with the ray on the driven transfer
	bit      row_pinned;
	result_t row_result;

	ray_sphere_intersect dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ray(ray),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [127:0] root_floor(input logic [127:0] v);
		logic [127:0] acc;
		logic [127:0] cand;
		acc = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = acc | (128'd1 << i);
			if (cand * cand <= v)
				acc = cand;
		end
		return acc;
	endfunction

	// exact fixed point intersection of one ray with the held sphere
	function automatic result_t sphere_hit(input ray_t r);
		logic signed [127:0] o [3];
		logic signed [127:0] c [3];
		logic signed [127:0] d [3];
		logic signed [127:0] s [3];
		logic signed [127:0] h [3];
		logic signed [127:0] n [3];
		logic signed [127:0] b, pos, neg, root, t1, t2, t, ts, len, nn, q;
		logic        [127:0] m;
		result_t res;
		res = '0;
		o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
		d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
		b = 0;
		neg = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = sphere_center[i];
			// out of range direction components clamp to plus or minus one
			if (d[i] > 128'sd1073741824) d[i] = 128'sd1073741824;
			if (d[i] < -128'sd1073741824) d[i] = -128'sd1073741824;
			s[i] = o[i] - c[i];
			b = b + ((d[i] * s[i]) >>> 30);
			neg = neg + s[i] * s[i];
		end
		pos = b * b + $signed({97'd0, sphere_rad}) * $signed({97'd0, sphere_rad});
		if (pos < neg)
			return res;
		root = $signed(root_floor(pos - neg));
		t1 = -b - root;
		t2 = -b + root;
		if (t2 < 0)
			return res;
		// a near root of exactly zero falls through to the far root
		t = (t1 > 0) ? t1 : t2;
		ts = (t > 128'sd2147483647) ? 128'sd2147483647 : t;
		nn = 0;
		for (int i = 0; i < 3; i++) begin
			h[i] = o[i] + ((ts * d[i]) >>> 30);
			if (h[i] > COORD_MAX) h[i] = COORD_MAX;
			if (h[i] < COORD_MIN) h[i] = COORD_MIN;
			n[i] = h[i] - c[i];
			nn = nn + n[i] * n[i];
		end
		len = $signed(root_floor(nn));
		res.hit = 1'b1;
		res.hit_distance = ts[30:0];
		res.hit_x = h[0][31:0];
		res.hit_y = h[1][31:0];
		res.hit_z = h[2][31:0];
		for (int i = 0; i < 3; i++) begin
			q = 0;
			if (len > 0) begin
				m = (n[i] < 0) ? -n[i] : n[i];
				q = $signed((m << 30) / len);
				if (n[i] < 0)
					q = -q;
			end
			case (i)
				0: begin res.normal_x = q[31:0]; res.toward_x = -d[0][31:0]; end
				1: begin res.normal_y = q[31:0]; res.toward_y = -d[1][31:0]; end
				default: begin res.normal_z = q[31:0]; res.toward_z = -d[2][31:0]; end
			endcase
		end
		return res;
	endfunction

	// predict on every accepted ray transfer
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (row_pinned)
				pending_hits.push_back(row_result);
			else
				pending_hits.push_back(sphere_hit(ray));
		end
	end

	// the block cannot be held off, so every strobe is one result transfer
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				error_count++;
			end else begin
				want = pending_hits.pop_front();
				if (result.hit !== want.hit || result.hit_distance !== want.hit_distance ||
					result.hit_x !== want.hit_x || result.hit_y !== want.hit_y ||
					result.hit_z !== want.hit_z || result.normal_x !== want.normal_x ||
					result.normal_y !== want.normal_y || result.normal_z !== want.normal_z ||
					result.toward_x !== want.toward_x || result.toward_y !== want.toward_y ||
					result.toward_z !== want.toward_z) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, result);
					error_count++;
				end
			end
		end
	end

	// setup then access; the register takes the value on the access edge
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_CENTER_X: sphere_center[0] = value;
			REG_CENTER_Y: sphere_center[1] = value;
			REG_CENTER_Z: sphere_center[2] = value;
			REG_RADIUS:   sphere_rad = value[30:0];
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_sphere(input logic [31:0] cx, input logic [31:0] cy,
		input logic [31:0] cz, input logic [31:0] rad);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_RADIUS, rad);
	endtask

	// sender gaps depend on how far the run has got
	task automatic sender_gap;
		int idle_pct;
		idle_pct = (ray_count < 140) ? 34 : ((ray_count < 280) ? 57 : 0);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// one ray transfer; start stays high into the next item if no gap follows
	task automatic send_ray(input ray_t r, input bit pinned, input result_t pin_res);
		sender_gap();
		start <= 1'b1;
		ray <= r;
		row_pinned <= pinned;
		row_result <= pin_res;
		@(posedge clk);
		while (busy) @(posedge clk);
		ray_count++;
	endtask

	task automatic drain_hits;
		start <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one in ten a raw bit pattern, the rest start near the sphere, half of those aimed at it
	function automatic ray_t aimed_ray();
		ray_t r;
		logic signed [63:0] off [3];
		logic signed [63:0] dv [3];
		real fx, fy, fz, flen;
		int span;
		int kind;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(9) == 0)
			return r;
		span = $urandom_range(3);
		for (int i = 0; i < 3; i++) begin
			case (span)
				0: off[i] = $signed(18'($urandom));
				1: off[i] = $signed(24'($urandom));
				2: off[i] = $signed(30'($urandom));
				default: off[i] = $signed(32'($urandom));
			endcase
			// jitter of the aim point, within eight radii per axis
			dv[i] = -off[i] + $signed(20'($urandom)) * $signed({1'b0, sphere_rad[30:16]});
		end
		r.origin_x = 32'(sphere_center[0] + off[0]);
		r.origin_y = 32'(sphere_center[1] + off[1]);
		r.origin_z = 32'(sphere_center[2] + off[2]);
		kind = $urandom_range(3);
		fx = dv[0];
		fy = dv[1];
		fz = dv[2];
		flen = $sqrt(fx * fx + fy * fy + fz * fz);
		if (kind < 2 && flen > 0.0) begin
			r.dir_x = $rtoi(fx / flen * 1073741824.0);
			r.dir_y = $rtoi(fy / flen * 1073741824.0);
			r.dir_z = $rtoi(fz / flen * 1073741824.0);
		end else if (kind == 2) begin
			r.dir_x = 0;
			r.dir_y = 0;
			r.dir_z = 0;
			case ($urandom_range(2))
				0: r.dir_x = $urandom_range(1) ? Q30_ONE : Q30_NEG;
				1: r.dir_y = $urandom_range(1) ? Q30_ONE : Q30_NEG;
				default: r.dir_z = $urandom_range(1) ? Q30_ONE : Q30_NEG;
			endcase
		end else begin
			r.dir_x = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
			r.dir_y = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
			r.dir_z = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
		end
		return r;
	endfunction

	task automatic random_rays(input int count);
		ray_t r;
		// a ray from the center itself, which gives a zero normal on a point sphere
		r = '0;
		r.origin_x = sphere_center[0];
		r.origin_y = sphere_center[1];
		r.origin_z = sphere_center[2];
		r.dir_y = Q30_ONE;
		send_ray(r, 1'b0, '0);
		for (int i = 0; i < count; i++)
			send_ray(aimed_ray(), 1'b0, '0);
	endtask

	initial begin
		probe_row_t rows [$];
		probe_row_t row;
		result_t front_hit;

		arst_n = 1'b0;
		start = 1'b0;
		ray = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		row_pinned = 1'b0;
		row_result = '0;
		error_count = 0;
		ray_count = 0;
		sphere_center[0] = 0;
		sphere_center[1] = 0;
		sphere_center[2] = 0;
		sphere_rad = 31'd65536;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit sphere at the origin after reset
		front_hit = '0;
		front_hit.hit = 1'b1;
		front_hit.hit_distance = 31'd65536;
		front_hit.hit_z = -Q16_ONE;
		front_hit.normal_z = Q30_NEG;
		front_hit.toward_z = Q30_NEG;

		// head on from two units back, typed in
		row = '{'{0, 0, -2 * Q16_ONE, 0, 0, Q30_ONE}, 1'b1, front_hit};
		rows.push_back(row);
		// passing sideways is a clean miss
		row = '{'{0, 0, -2 * Q16_ONE, Q30_ONE, 0, 0}, 1'b1, '0};
		rows.push_back(row);
		// sphere entirely behind the ray
		row = '{'{0, 0, 2 * Q16_ONE, 0, 0, Q30_ONE}, 1'b1, '0};
		rows.push_back(row);
		// from the inside, near root negative
		row = '{'{0, 0, 0, 0, 0, Q30_ONE}, 1'b0, '0};
		rows.push_back(row);
		// on the surface heading out, far root exactly zero
		row = '{'{0, 0, Q16_ONE, 0, 0, Q30_ONE}, 1'b0, '0};
		rows.push_back(row);
		// on the surface heading in, near root exactly zero
		row = '{'{0, 0, -Q16_ONE, 0, 0, Q30_ONE}, 1'b0, '0};
		rows.push_back(row);
		// grazing, zero discriminant
		row = '{'{Q16_ONE, 0, -2 * Q16_ONE, 0, 0, Q30_ONE}, 1'b0, '0};
		rows.push_back(row);
		// direction components beyond one clamp
		row = '{'{0, 0, -2 * Q16_ONE, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF},
			1'b0, '0};
		rows.push_back(row);
		// coordinate extremes
		row = '{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, Q30_NEG, Q30_ONE, Q30_NEG},
			1'b0, '0};
		rows.push_back(row);
		row = '{'{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, Q30_NEG, Q30_NEG, Q30_NEG},
			1'b0, '0};
		rows.push_back(row);
		// zero direction at the center
		row = '{'{0, 0, 0, 0, 0, 0}, 1'b0, '0};
		rows.push_back(row);
		row = '{'{32'sh0000_8000, 32'shFFFF_8000, 32'sh0001_0000, 32'sh2000_0000,
			32'shD000_0000, 32'sh2D41_3CCD}, 1'b0, '0};
		rows.push_back(row);

		foreach (rows[i])
			send_ray(rows[i].ray, rows[i].pinned, rows[i].result);
		// hold off until the whole pipeline has emptied
		drain_hits();
		random_rays(60);
		drain_hits();

		// point sphere at the origin
		load_sphere(32'd0, 32'd0, 32'd0, 32'd0);
		random_rays(60);
		drain_hits();

		// far corner centers, largest radius, distances that saturate
		load_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		random_rays(60);
		drain_hits();

		load_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		random_rays(40);
		drain_hits();

		// small random spheres near the origin
		for (int k = 0; k < 4; k++) begin
			load_sphere($signed(24'($urandom)), $signed(24'($urandom)),
				$signed(24'($urandom)), $urandom_range(32'h0080_0000));
			random_rays(30);
			drain_hits();
		end

		// fully random setting
		load_sphere($urandom, $urandom, $urandom, $urandom);
		random_rays(40);
		drain_hits();

		repeat (PIPE_CYCLES + 16) @(posedge clk);
		if (error_count == 0 && pending_hits.size() == 0)
			$display("ray_sphere_intersect_test: PASS");
		else
			$display("ray_sphere_intersect_test: FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5ms;
		$display("ray_sphere_intersect_test: FAIL");
		$finish;
	end

endmodule

[ray_sphere_intersect.f]
+incdir+rtl/core
rtl/core/rsi_pkg.sv
rtl/core/rsi_sqrt.sv
rtl/core/rsi_div.sv
rtl/core/ray_sphere_intersect.sv
bench/ray_sphere_intersect_test.sv
